@@ rtl/owsc_pkg.sv @@
// Shared types, constants and the CRC-8 step for the scratchpad checker.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package owsc_pkg;

	// Field widths of the two channels.
	localparam int DATA_W = 8;
	localparam int TEMP_W = 19;
	localparam int RAW_W  = 16;

	// Scratchpad layout and the error reading.
	localparam int                  MARKER_INDEX = 7;
	localparam logic [DATA_W-1:0]   MARKER_VALUE = 8'h10;
	localparam logic signed [TEMP_W-1:0] ERROR_TEMP = -19'sd27315;

	// Reflected Dallas/Maxim polynomial; its table entry for 1 is 94.
	localparam logic [DATA_W-1:0]   CRC_POLY = 8'h8C;

	// What the state stage hands to the temperature stage on the CRC byte.
	typedef struct packed {
		logic                  ok;
		logic [RAW_W-1:0]      raw;
	} res_t;

	// One byte through the CRC, bit by bit, LSB first.
	function automatic logic [DATA_W-1:0] crc8_update(input logic [DATA_W-1:0] crc,
		input logic [DATA_W-1:0] b);
		logic [DATA_W-1:0] v;
		v = crc ^ b;
		for (int k = 0; k < DATA_W; k++) begin
			v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
		end
		return v;
	endfunction

endpackage

`default_nettype wire

@@ rtl/owsc_state.sv @@
// Scratchpad state stage: a single-entry state memory read ahead into a register,
// updated per byte and written back, with forwarding between adjacent beats.
// Depends on owsc_pkg.
`default_nettype none

module owsc_state #(
	parameter int CRC_COVERED_BYTES = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire logic                       acc,
	input  wire logic [owsc_pkg::DATA_W-1:0] data_byte,
	input  wire logic                       first,
	output      logic                       res_v,
	output      owsc_pkg::res_t             res
);
	import owsc_pkg::*;

	localparam int CW = $clog2(CRC_COVERED_BYTES + 2);

	typedef struct packed {
		logic [CW-1:0]     cnt;
		logic [DATA_W-1:0] crc;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
		logic              mok;
	} state_t;

	state_t            state_mem [1];
	logic              mem_vld_q;

	logic              valid_s1;
	logic              fwd_s1;
	logic              vld_s1;
	state_t            rd_s1;
	state_t            wdata_s1;
	logic [DATA_W-1:0] byte_s1;
	logic              first_s1;

	state_t            cur;
	state_t            base;
	state_t            nxt;
	logic [CW-1:0]     idx;
	logic              emit;
	logic              we;

	assign we = valid_s1 && adv;

	// State memory: written by the beat leaving the stage, read for the beat entering.
	always_ff @(posedge clk) begin
		if (we) begin
			state_mem[0] <= nxt;
		end
		if (adv) begin
			rd_s1    <= state_mem[0];
			wdata_s1 <= nxt;
			byte_s1  <= data_byte;
			first_s1 <= first;
		end
	end

	// Control of the stage; the memory counts as cleared until its first write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_q <= 1'b0;
			valid_s1  <= 1'b0;
			fwd_s1    <= 1'b0;
			vld_s1    <= 1'b0;
		end else begin
			if (we) begin
				mem_vld_q <= 1'b1;
			end
			if (adv) begin
				valid_s1 <= acc;
				fwd_s1   <= valid_s1;
				vld_s1   <= mem_vld_q;
			end
		end
	end

	// Current state: the write of the previous beat wins over the stale read.
	always_comb begin
		priority if (fwd_s1) begin
			cur = wdata_s1;
		end else if (vld_s1) begin
			cur = rd_s1;
		end else begin
			cur = '0;
		end
	end

	// Per-byte update of count, CRC, raw temperature and marker check.
	always_comb begin
		base = cur;
		if (first_s1) begin
			base.cnt = '0;
			base.crc = '0;
			base.mok = 1'b0;
		end
		idx  = base.cnt;
		nxt  = base;
		emit = 1'b0;
		if (idx <= CW'(CRC_COVERED_BYTES)) begin
			if (idx == '0) begin
				nxt.lo = byte_s1;
			end
			if (idx == CW'(1)) begin
				nxt.hi = byte_s1;
			end
			if (int'(idx) == MARKER_INDEX) begin
				nxt.mok = (byte_s1 == MARKER_VALUE);
			end
			if (idx < CW'(CRC_COVERED_BYTES)) begin
				nxt.crc = crc8_update(base.crc, byte_s1);
				nxt.cnt = idx + CW'(1);
			end else begin
				nxt.cnt = CW'(CRC_COVERED_BYTES + 1);
				emit    = 1'b1;
			end
		end
	end

	// Result request towards the temperature stage.
	always_comb begin
		res_v   = valid_s1 && emit;
		res.ok  = (byte_s1 == base.crc) && nxt.mok;
		res.raw = {nxt.hi, nxt.lo};
	end

	// A good result always has seen a matching marker byte.
	a_ok_needs_marker: assert property (@(posedge clk) disable iff (!arst_n)
		res_v && res.ok |-> nxt.mok)
		else $error("good result without marker check");

	// After every write-back the next beat takes the forwarded state.
	a_fwd_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> fwd_s1)
		else $error("write-back not forwarded");

endmodule

`default_nettype wire

@@ rtl/owsc_temp.sv @@
// Temperature stage and output register: scales the raw reading to hundredths
// of a degree and holds the result beat for the receiver. Depends on owsc_pkg.
`default_nettype none

module owsc_temp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              res_v,
	input  wire owsc_pkg::res_t                    res,
	input  wire logic                              out_stall,
	output      logic                              adv,
	output      logic                              out_valid,
	output      logic signed [owsc_pkg::TEMP_W-1:0] temperature_centi,
	output      logic                              valid_res
);
	import owsc_pkg::*;

	logic                      s2_v;
	res_t                      res_s2;
	logic                      s2_go;
	logic signed [TEMP_W-1:0]  rw;
	logic signed [TEMP_W-1:0]  quarter;
	logic signed [TEMP_W-1:0]  scaled;

	// The held result moves on when the output register is free or being taken.
	assign s2_go = !out_valid || !out_stall;
	assign adv   = !s2_v || s2_go;

	// raw*6 + raw/4 with the quarter rounded toward zero.
	always_comb begin
		rw      = TEMP_W'(signed'(res_s2.raw));
		quarter = (rw + (rw[TEMP_W-1] ? TEMP_W'(3) : TEMP_W'(0))) >>> 2;
		scaled  = (rw <<< 2) + (rw <<< 1) + quarter;
	end

	// Control of the result stage and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv) begin
				s2_v <= res_v;
			end
			if (s2_go) begin
				out_valid <= s2_v;
			end
		end
	end

	// Payload of both registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
		if (s2_go) begin
			temperature_centi <= res_s2.ok ? scaled : ERROR_TEMP;
			valid_res         <= res_s2.ok;
		end
	end

	// An error beat carries the error reading.
	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> temperature_centi == ERROR_TEMP)
		else $error("error beat with wrong temperature");

	// The upstream stage only waits when both result registers are occupied.
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> s2_v && out_valid && out_stall)
		else $error("upstream held without full result registers");

	// A waiting result is never dropped while the receiver stalls.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v && out_valid && out_stall |=> s2_v)
		else $error("held result lost");

endmodule

`default_nettype wire

@@ rtl/onewire_scratchpad_checker_unit.sv @@
// Checker for a 1-Wire temperature sensor scratchpad: top level.
// Input beats carry one scratchpad byte each, with first marking byte 0 of a
// read. Bytes 0 to CRC_COVERED_BYTES-1 go through the Dallas/Maxim CRC-8;
// the next byte is the received CRC, and on it one output beat appears:
// temperature_centi = raw*6 + raw/4 and valid_res = 1 when the CRC matches
// and byte 7 is 0x10, otherwise -27315 with valid_res = 0. Bytes after the
// CRC byte give nothing until the next first flag.
// Throughput is one byte per cycle while the input is not stalled: the state
// sits in a single-entry memory read ahead into a register, and the state
// stage forwards its own write-back to the byte behind it. The CRC byte's
// result passes the state stage, temperature stage and output register.
// Reset clears the pipeline and marks the state memory empty, so the stream
// starts at byte 0 even without a first flag. When the receiver stalls, the
// output register and one further result register absorb results; input is
// stalled only when both are full, and bytes that cause no result keep
// flowing until then.
// Depends on owsc_pkg, owsc_state and owsc_temp.
`default_nettype none

module onewire_scratchpad_checker_unit #(
	parameter int CRC_COVERED_BYTES = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output      logic                              in_stall,
	input  wire logic [owsc_pkg::DATA_W-1:0]        data_byte,
	input  wire logic                              first,
	output      logic                              out_valid,
	input  wire logic                              out_stall,
	output      logic signed [owsc_pkg::TEMP_W-1:0] temperature_centi,
	output      logic                              valid_res
);
	import owsc_pkg::*;

	logic adv;
	logic acc;
	logic res_v;
	res_t res;

	// Input beats are taken whenever the pipeline advances.
	assign in_stall = !adv;
	assign acc      = in_valid && adv;

	// Per-byte state update against the state memory.
	owsc_state #(
		.CRC_COVERED_BYTES(CRC_COVERED_BYTES)
	) u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.acc       (acc),
		.data_byte (data_byte),
		.first     (first),
		.res_v     (res_v),
		.res       (res)
	);

	// Scaling and result delivery.
	owsc_temp u_temp (
		.clk               (clk),
		.arst_n            (arst_n),
		.res_v             (res_v),
		.res               (res),
		.out_stall         (out_stall),
		.adv               (adv),
		.out_valid         (out_valid),
		.temperature_centi (temperature_centi),
		.valid_res         (valid_res)
	);

endmodule

`default_nettype wire

@@ tb/sv/onewire_scratchpad_checker_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for onewire_scratchpad_checker_unit: scratchpad bytes in, one
// temperature reading per complete read out, checked against a cycle-free model of the checker.
// Depends on owsc_pkg and the RTL of the block; reads nothing from outside.

module onewire_scratchpad_checker_unit_test;

	import owsc_pkg::*;

	localparam int COVERED       = 8;     // bytes under the CRC; the next one is the CRC
	localparam int READ_BYTES    = 2000;  // scratchpad bytes to offer in the random part
	localparam int WATCHDOG      = 2000;  // cycles without any beat before giving up
	localparam int HOLD_CYCLES   = 300;   // one long receiver hold-off
	localparam int HOLD_AFTER    = 40;    // readings checked before the hold-off starts
	localparam int DRAIN_CYCLES  = 10;
	localparam int REPORT_LIMIT  = 10;

	typedef struct {
		logic [DATA_W-1:0] data;
		logic              first;
	} sp_beat_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic                     ok;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [DATA_W-1:0] data_byte = '0;
	logic first = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [TEMP_W-1:0] temperature_centi;
	logic valid_res;

	// Bytes waiting to be driven and readings waiting to come out.
	sp_beat_t byte_q[$];
	reading_t reading_q[$];

	// Copy of the checker's state, advanced on every accepted input beat.
	logic [3:0]        rd_index = '0;
	logic [DATA_W-1:0] rd_crc = '0;
	logic [DATA_W-1:0] rd_lo = '0;
	logic [DATA_W-1:0] rd_hi = '0;
	logic              rd_marker = 1'b0;

	// Handshake flags from the last rising edge, used by the falling-edge drivers.
	logic byte_acc = 1'b0;
	logic res_acc = 1'b0;

	int read_bytes = 0;
	int bytes_seen = 0;
	int readings_seen = 0;
	int good_seen = 0;
	int input_stalls = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	onewire_scratchpad_checker_unit #(
		.CRC_COVERED_BYTES(COVERED)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.first(first),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.temperature_centi(temperature_centi),
		.valid_res(valid_res)
	);

	always #4 clk = ~clk;

	// Dallas/Maxim CRC-8, one data bit at a time, least significant bit first.
	function automatic logic [DATA_W-1:0] crc_byte(input logic [DATA_W-1:0] crc,
		input logic [DATA_W-1:0] b);
		logic [DATA_W-1:0] c;
		logic fb;
		c = crc;
		for (int k = 0; k < DATA_W; k++) begin
			fb = c[0] ^ b[k];
			c = c >> 1;
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	// Advances the scratchpad state by one byte; returns 1 with the reading on the CRC byte.
	function automatic bit scratch_step(input logic [DATA_W-1:0] b, input logic f,
		output reading_t r);
		logic signed [RAW_W-1:0] raw16;
		int raw;
		int t;
		r = '0;
		if (f) begin
			rd_index = '0;
			rd_crc = '0;
			rd_marker = 1'b0;
		end
		if (rd_index > COVERED)
			return 1'b0;
		if (rd_index == 0)
			rd_lo = b;
		if (rd_index == 1)
			rd_hi = b;
		if (rd_index == MARKER_INDEX)
			rd_marker = (b == MARKER_VALUE);
		if (rd_index < COVERED) begin
			rd_crc = crc_byte(rd_crc, b);
			rd_index = rd_index + 1'b1;
			return 1'b0;
		end
		rd_index = 4'(COVERED + 1);
		if (b == rd_crc && rd_marker) begin
			raw16 = {rd_hi, rd_lo};
			raw = raw16;
			t = raw * 6 + raw / 4;
			r.temp = TEMP_W'(t);
			r.ok = 1'b1;
		end else begin
			r.temp = ERROR_TEMP;
			r.ok = 1'b0;
		end
		return 1'b1;
	endfunction

	// Queues one scratchpad read, possibly cut short, with a good or corrupted CRC.
	function automatic void queue_read(input logic [RAW_W-1:0] raw, input logic [DATA_W-1:0] marker,
		input bit crc_good, input bit with_first, input int n_bytes);
		logic [DATA_W-1:0] pad[0:8];
		logic [DATA_W-1:0] c;
		sp_beat_t bt;
		pad[0] = raw[7:0];
		pad[1] = raw[15:8];
		for (int k = 2; k < MARKER_INDEX; k++)
			pad[k] = DATA_W'($urandom);
		pad[MARKER_INDEX] = marker;
		c = '0;
		for (int k = 0; k < COVERED; k++)
			c = crc_byte(c, pad[k]);
		pad[COVERED] = crc_good ? c : c ^ DATA_W'($urandom_range(1, 255));
		for (int k = 0; k < n_bytes; k++) begin
			bt.data = pad[k];
			bt.first = (k == 0) && with_first;
			byte_q.push_back(bt);
		end
		read_bytes += n_bytes;
	endfunction

	// Stray bytes with no first flag; after a finished read the block should ignore them.
	function automatic void queue_junk(input int n);
		sp_beat_t bt;
		for (int k = 0; k < n; k++) begin
			bt.data = DATA_W'($urandom);
			bt.first = 1'b0;
			byte_q.push_back(bt);
		end
	endfunction

	// Sender: offers queued bytes at the falling edge, with a random gap after each beat.
	always @(negedge clk) begin
		sp_beat_t nb;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !byte_acc) begin
			// Stalled: the beat stays on the bus unchanged.
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (byte_q.size() != 0) begin
			nb = byte_q.pop_front();
			in_valid <= 1'b1;
			data_byte <= nb.data;
			first <= nb.first;
			if ($urandom_range(0, 63) == 0)
				tx_calm <= !tx_calm;
			gap_left <= tx_calm ? 0 : $urandom_range(0, 15);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: random stall after each reading, plus one long hold-off to fill the block.
	always @(negedge clk) begin
		int nxt;
		nxt = stall_left;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && readings_seen >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			if (res_acc) begin
				if ($urandom_range(0, 49) == 0)
					rx_calm = !rx_calm;
				nxt = rx_calm ? 0 : $urandom_range(0, 15);
			end
			if (nxt > 0) begin
				out_stall <= 1'b1;
				stall_left <= nxt - 1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= 0;
			end
		end
	end

	// Monitor: predicts on every accepted byte and checks every accepted reading.
	always @(posedge clk) begin
		reading_t want;
		reading_t got;
		byte_acc <= arst_n && in_valid && !in_stall;
		res_acc <= arst_n && out_valid && !out_stall;
		if (arst_n && in_valid && in_stall)
			input_stalls++;
		if (arst_n && in_valid && !in_stall) begin
			bytes_seen++;
			if (scratch_step(data_byte, first, want))
				reading_q.push_back(want);
		end
		if (arst_n && out_valid && !out_stall) begin
			got.temp = temperature_centi;
			got.ok = valid_res;
			readings_seen++;
			if (valid_res)
				good_seen++;
			if (reading_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected reading temp=%0d ok=%0b", $realtime,
						got.temp, got.ok);
			end else begin
				want = reading_q.pop_front();
				if (got.temp !== want.temp || got.ok !== want.ok) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: reading %0d expected temp=%0d ok=%0b, got temp=%0d ok=%0b",
							$realtime, readings_seen, want.temp, want.ok, got.temp, got.ok);
				end
			end
		end
	end

	// Watchdog: gives up when no beat moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Watchdog: no beat for %0d cycles, %0d readings outstanding.",
				WATCHDOG, reading_q.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// Stimulus, reset and the end of the run.
	initial begin
		logic [RAW_W-1:0] corner[0:4];
		logic [RAW_W-1:0] raw;
		int leftover;
		corner = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h8300};

		// Directed: a read with no first flag straight after reset, raw value -32000.
		queue_read(16'h8300, MARKER_VALUE, 1'b1, 1'b0, 9);
		// Bytes after the CRC byte must give nothing.
		queue_junk(2);
		// A read cut short, then restarted by a first flag with a bad CRC.
		queue_read(16'h8000, MARKER_VALUE, 1'b1, 1'b1, 4);
		queue_read(16'h7FFF, MARKER_VALUE, 1'b0, 1'b1, 9);
		read_bytes = 0;

		// Random: mostly well-formed reads, some cut short, bad marker, bad CRC or trailed.
		while (read_bytes < READ_BYTES) begin
			raw = RAW_W'($urandom);
			if ($urandom_range(0, 15) == 0)
				raw = corner[$urandom_range(0, 4)];
			queue_read(raw,
				($urandom_range(0, 7) == 0) ? DATA_W'($urandom) : MARKER_VALUE,
				$urandom_range(0, 7) != 0,
				$urandom_range(0, 15) != 0,
				($urandom_range(0, 15) == 0) ? $urandom_range(1, COVERED) : COVERED + 1);
			if ($urandom_range(0, 9) == 0)
				queue_junk($urandom_range(1, 4));
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (byte_q.size() == 0 && !in_valid && reading_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		leftover = reading_q.size();
		if (leftover != 0)
			$display("%0d expected readings never arrived.", leftover);
		$display("Drove %0d scratchpad bytes; checked %0d readings (%0d good, %0d rejected).",
			bytes_seen, readings_seen, good_seen, readings_seen - good_seen);
		$display("Input was held by back-pressure for %0d cycles; %0d mismatches.",
			input_stalls, mismatches);
		if (mismatches == 0 && leftover == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
